### sv/page_free_list_allocator_defines.svh
// Assertion macros used by the request control of the page free list allocator.
`ifndef PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, quiet in reset
`define PFLA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfla assertion failed");

// next-cycle implication, sampled on clk, quiet in reset
`define PFLA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfla assertion failed");

`else

`define PFLA_ASSERT_NOW(label, ante, cons)
`define PFLA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/pfla_pkg.sv
// Types and constants of the page free list allocator.
package pfla_pkg;

	localparam int MAX_PAGES  = 65536;
	localparam int PAGE_BYTES = 4096;

	localparam int IDX_W      = $clog2(MAX_PAGES);
	localparam int LINK_W     = $clog2(MAX_PAGES + 1);
	localparam int OFF_W      = $clog2(PAGE_BYTES);
	localparam int ADDR_W     = 32;
	localparam int PHYS_TOP_W = 29;
	localparam int REG_IDX_W  = 2;
	localparam int STATUS_W   = 2;

	localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(MAX_PAGES);

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_KERNEL_END  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_KERNEL_BASE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PHYS_TOP    = 2'd2;

	localparam logic [ADDR_W-1:0]     KERNEL_END_RST  = 32'h0000_0000;
	localparam logic [ADDR_W-1:0]     KERNEL_BASE_RST = 32'h8000_0000;
	localparam logic [PHYS_TOP_W-1:0] PHYS_TOP_RST    = 29'h0E00_0000;

	typedef struct packed {
		logic [ADDR_W-1:0]     kernel_end;
		logic [ADDR_W-1:0]     kernel_base;
		logic [PHYS_TOP_W-1:0] phys_top;
	} cfg_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

endpackage

### sv/pfla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pfla_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/pfla_cfg.sv
// Configuration register file of the page free list allocator.
module pfla_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pfla_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [pfla_pkg::ADDR_W-1:0]     cfg_data,
	output pfla_pkg::cfg_t                  cfg
);
	import pfla_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_end  <= KERNEL_END_RST;
			cfg_q.kernel_base <= KERNEL_BASE_RST;
			cfg_q.phys_top    <= PHYS_TOP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KERNEL_END:  cfg_q.kernel_end  <= cfg_data;
				REG_KERNEL_BASE: cfg_q.kernel_base <= cfg_data;
				REG_PHYS_TOP:    cfg_q.phys_top    <= cfg_data[PHYS_TOP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/pfla_ctrl.sv
// Request control, head register and result register of the allocator.
`include "page_free_list_allocator_defines.svh"

module pfla_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfla_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [pfla_pkg::ADDR_W-1:0]    page_addr,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pfla_pkg::ADDR_W-1:0]    alloc_addr,
	output logic [pfla_pkg::STATUS_W-1:0]  status,
	output logic                           mem_we,
	output logic [pfla_pkg::IDX_W-1:0]     mem_waddr,
	output logic [pfla_pkg::LINK_W-1:0]    mem_wdata,
	output logic                           mem_re,
	output logic [pfla_pkg::IDX_W-1:0]     mem_raddr,
	input  logic [pfla_pkg::LINK_W-1:0]    mem_rdata
);
	import pfla_pkg::*;

	state_t state_q, state_d;

	logic [LINK_W-1:0]   head_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   alloc_addr_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   pop_addr_s1;

	logic                accept;
	logic                list_empty;
	logic [ADDR_W-1:0]   phys;
	logic [ADDR_W-1:0]   phys_page;
	logic [IDX_W-1:0]    free_idx;
	logic                free_ok;
	logic [ADDR_W-1:0]   frac;
	logic [ADDR_W-1:0]   head_virt;
	logic                load_out;
	logic [ADDR_W-1:0]   load_addr;
	logic [STATUS_W-1:0] load_status;
	logic                head_we;
	logic [LINK_W-1:0]   head_d;

	assign list_empty = (head_q >= EMPTY_MARK);
	assign phys       = page_addr - cfg.kernel_base;
	assign phys_page  = phys >> OFF_W;
	assign free_idx   = phys[OFF_W +: IDX_W];
	assign free_ok    = (page_addr[OFF_W-1:0] == '0) &&
	                    (page_addr >= cfg.kernel_end) &&
	                    (phys < ADDR_W'(cfg.phys_top)) &&
	                    (phys_page < ADDR_W'(MAX_PAGES));

	assign frac      = (ADDR_W'(0) - cfg.kernel_base) & ADDR_W'(PAGE_BYTES - 1);
	assign head_virt = ((ADDR_W'(head_q) << OFF_W) | frac) + cfg.kernel_base;

	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (func == FUNC_ALLOC) && !list_empty) begin
					state_d = ST_POP;
				end
			end
			ST_POP:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		load_out    = 1'b0;
		load_addr   = '0;
		load_status = STAT_OK;
		head_we     = 1'b0;
		head_d      = mem_rdata;
		case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (accept) begin
					if (func == FUNC_FREE) begin
						load_out    = 1'b1;
						load_status = free_ok ? STAT_OK : STAT_INVALID;
						mem_we      = free_ok;
						head_we     = free_ok;
						head_d      = LINK_W'(free_idx);
					end else if (list_empty) begin
						load_out    = 1'b1;
						load_status = STAT_EMPTY;
					end else begin
						mem_re = 1'b1;
					end
				end
			end
			ST_POP: begin
				load_out  = 1'b1;
				load_addr = pop_addr_s1;
				head_we   = 1'b1;
			end
			default: ;
		endcase
	end

	assign mem_waddr = free_idx;
	assign mem_wdata = head_q;
	assign mem_raddr = head_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= EMPTY_MARK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (head_we) begin
				head_q <= head_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			pop_addr_s1 <= head_virt;
		end
		if (load_out) begin
			alloc_addr_q <= load_addr;
			status_q     <= load_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign alloc_addr = alloc_addr_q;
	assign status     = status_q;

	`PFLA_ASSERT_NOW(a_pop_slot_free, state_q == ST_POP, !out_valid_q)
	`PFLA_ASSERT_NEXT(a_pop_one_cycle, state_q == ST_POP, state_q == ST_IDLE)
	`PFLA_ASSERT_NEXT(a_pop_after_read, mem_re, state_q == ST_POP && !out_valid_q)
	`PFLA_ASSERT_NOW(a_no_addr_unless_ok, out_valid_q && status_q != STAT_OK, alloc_addr_q == '0)
	`PFLA_ASSERT_NEXT(a_push_sets_head, mem_we, head_q == LINK_W'($past(free_idx)))

endmodule

### sv/page_free_list_allocator.sv
// Top level of the page free list allocator.
// Pages form a last-in-first-out linked list whose links sit in a single
// synchronous RAM of MAX_PAGES entries; the head index sits in a register.
// A free request is checked and, when valid, pushed as it is accepted. An
// allocate request on an empty list is answered as it is accepted; otherwise
// it passes through the pop state, because the link of the new head must come
// back from the link RAM before the next request can pop. One request is in
// flight at a time; a finished result waits in an output register, and the
// next request is taken only once that register is empty or is being read in
// the same cycle. The link RAM needs no clearing after reset: an entry is only
// read once the page has been pushed. Configuration writes take effect at the
// next clock edge and are meant to be made while no request is in flight.
module page_free_list_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [pfla_pkg::ADDR_W-1:0]    page_addr,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pfla_pkg::ADDR_W-1:0]    alloc_addr,
	output logic [pfla_pkg::STATUS_W-1:0]  status,
	input  logic                           cfg_we,
	input  logic [pfla_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [pfla_pkg::ADDR_W-1:0]    cfg_data
);
	import pfla_pkg::*;

	cfg_t              cfg;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [LINK_W-1:0] mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic [LINK_W-1:0] mem_rdata;

	pfla_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfla_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.page_addr  (page_addr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.alloc_addr (alloc_addr),
		.status     (status),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	pfla_ram #(
		.WIDTH  (LINK_W),
		.DEPTH  (MAX_PAGES),
		.ADDR_W (IDX_W)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
